// File: rtl/fill_rect_chunk_splitter_assert.svh
// ----------------------------------------------------------------------------
// fill_rect_chunk_splitter_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef FILL_RECT_CHUNK_SPLITTER_ASSERT_SVH
`define FILL_RECT_CHUNK_SPLITTER_ASSERT_SVH

// same-cycle implication
`define FRCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frcs assertion failed");

// next-cycle implication
`define FRCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frcs assertion failed");

`endif

// File: rtl/frcs_pkg.sv
// ----------------------------------------------------------------------------
// frcs_pkg
// constants, types and helpers of the fill rectangle chunk splitter
// ----------------------------------------------------------------------------
`default_nettype none

package frcs_pkg;

    localparam int DISPLAY_WIDTH  = 320;
    localparam int DISPLAY_HEIGHT = 240;
    localparam int CHUNK_PIXELS   = 5120;
    localparam int MAX_RESULTS    = 32;

    localparam int COLOR_W  = 24;
    localparam int RGB565_W = 16;
    localparam int COORD_W  = 9;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;

    // widest pixel total that can pass the bounds check
    localparam int TOTAL_W   = $clog2(DISPLAY_WIDTH * DISPLAY_HEIGHT + 1);
    localparam int CHUNK_W   = $clog2(CHUNK_PIXELS + 1);
    localparam int CMP_W     = (TOTAL_W > CHUNK_W) ? TOTAL_W : CHUNK_W;
    localparam int RES_W     = $clog2(MAX_RESULTS);
    localparam int DIV_CNT_W = $clog2(TOTAL_W + 1);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_CHUNK  = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_EMPTY  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] dividend;
        logic [COORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] quotient;
        logic [COORD_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [COORD_W-1:0]  win_x_first;
        logic [COORD_W-1:0]  win_x_last;
        logic [COORD_W-1:0]  win_y_first;
        logic [COORD_W-1:0]  win_y_last;
        logic [COUNT_W-1:0]  pixel_count;
        logic [RGB565_W-1:0] color_rgb565;
        status_t             status;
        logic                last;
    } res_t;

    function automatic logic [RGB565_W-1:0] to_565(input logic [COLOR_W-1:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/frcs_if.sv
// ----------------------------------------------------------------------------
// frcs_cmd_if / frcs_chunk_if
// valid/ready channels for fill commands and chunk results
// ----------------------------------------------------------------------------
`default_nettype none

interface frcs_cmd_if;
    import frcs_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color_rgb888;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] x_width;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] y_span;

    modport source (
        output valid, color_rgb888, x_start, x_width, y_start, y_span,
        input  ready
    );
    modport sink (
        input  valid, color_rgb888, x_start, x_width, y_start, y_span,
        output ready
    );
endinterface

interface frcs_chunk_if;
    import frcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [COORD_W-1:0]  win_x_first;
    logic [COORD_W-1:0]  win_x_last;
    logic [COORD_W-1:0]  win_y_first;
    logic [COORD_W-1:0]  win_y_last;
    logic [COUNT_W-1:0]  pixel_count;
    logic [RGB565_W-1:0] color_rgb565;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (
        output valid, win_x_first, win_x_last, win_y_first, win_y_last,
               pixel_count, color_rgb565, status, last,
        input  ready
    );
    modport sink (
        input  valid, win_x_first, win_x_last, win_y_first, win_y_last,
               pixel_count, color_rgb565, status, last,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/frcs_div.sv
// ----------------------------------------------------------------------------
// frcs_div
// restoring divider, one quotient bit per cycle, splits a pixel offset
// into row and column
// ----------------------------------------------------------------------------
`default_nettype none

module frcs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  frcs_pkg::div_req_t req,
    output frcs_pkg::div_rsp_t rsp
);
    import frcs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [TOTAL_W-1:0]   quo_reg, quo_next;
    logic [COORD_W-1:0]   dsr_reg, dsr_next;

    logic [COORD_W:0]     trial;
    logic [COORD_W:0]     diff;
    logic                 fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[TOTAL_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so it fits COORD_W bits
            rem_next = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            quo_next = (quo_reg << 1) | TOTAL_W'(fits);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(TOTAL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/fill_rect_chunk_splitter.sv
// ----------------------------------------------------------------------------
// fill_rect_chunk_splitter
// splits a solid-fill rectangle into clipped display windows with pixel counts
// ----------------------------------------------------------------------------
// usage
//   cmd takes one fill command (rgb888 color, start point, size); chunk gives
//   one item per window, the final one of a command flagged with last.
//   a rectangle past the display edge gives one rejected item, an empty one
//   gives one empty item; both carry zero window, count and color.
//   cmd.ready is high only while no command is in work; a command is taken
//   again as soon as its final item sits in the output register.
//   a rejected or empty item is loaded in the check state once the output
//   register is free. for each chunk the shared restoring divider turns the
//   pixel offset into row and column one bit a cycle; the sequencer starts it,
//   waits for its done and then emits the chunk.
//   when chunk.ready is low the output register holds its item; the next
//   division still runs and the sequencer waits at emit until the slot frees.
//   reset clears the sequencer and the output valid flag; no item is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module fill_rect_chunk_splitter (
    input  logic         clk,
    input  logic         rst_n,
    frcs_cmd_if.sink     cmd,
    frcs_chunk_if.source chunk
);
    import frcs_pkg::*;

    state_t             state_reg, state_next;

    logic [COLOR_W-1:0] color_reg;
    logic [COORD_W-1:0] xs_reg, xw_reg, ys_reg, yh_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] pixels_done_reg, pixels_done_next;
    logic [RES_W-1:0]   n_reg, n_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;

    logic               cmd_fire;
    logic               out_free;
    logic               oob;
    logic               empty;

    logic               latch_cmd;
    logic               load_total;
    logic               load_status;
    logic               load_chunk;
    logic               div_start;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [COORD_W:0]     x1_sum, y1_sum;
    logic [COORD_W+1:0]   x2_sum, y2_sum;
    logic [COORD_W-1:0]   x2_clip, y2_clip;
    logic [TOTAL_W-1:0]   npix_raw, npix;
    logic [TOTAL_W-1:0]   done_sum;
    logic                 fin;
    logic [2*COORD_W-1:0] product;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || chunk.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    assign oob = (({1'b0, xs_reg} + {1'b0, xw_reg}) > (COORD_W+1)'(DISPLAY_WIDTH)) ||
                 (({1'b0, ys_reg} + {1'b0, yh_reg}) > (COORD_W+1)'(DISPLAY_HEIGHT));
    assign empty   = (xw_reg == '0) || (yh_reg == '0);
    assign product = xw_reg * yh_reg;

    // chunk geometry from the divider's row and column of the next pixel
    always_comb
    begin
        x1_sum = {1'b0, xs_reg} + {1'b0, div_rsp.remainder};
        y1_sum = {1'b0, ys_reg} + {1'b0, COORD_W'(div_rsp.quotient)};
        x2_sum = (COORD_W+2)'(x1_sum) + (COORD_W+2)'(xw_reg) - 1'b1;
        y2_sum = (COORD_W+2)'(y1_sum) + (COORD_W+2)'(yh_reg) - 1'b1;
        x2_clip = (x2_sum > (COORD_W+2)'(DISPLAY_WIDTH - 1))
                  ? COORD_W'(DISPLAY_WIDTH - 1) : x2_sum[COORD_W-1:0];
        y2_clip = (y2_sum > (COORD_W+2)'(DISPLAY_HEIGHT - 1))
                  ? COORD_W'(DISPLAY_HEIGHT - 1) : y2_sum[COORD_W-1:0];

        // mid-row start finishes only that row
        if (div_rsp.remainder != '0)
            npix_raw = TOTAL_W'(xw_reg - div_rsp.remainder);
        else
            npix_raw = total_reg - pixels_done_reg;

        if (CMP_W'(npix_raw) > CMP_W'(CHUNK_PIXELS))
            npix = TOTAL_W'(CHUNK_PIXELS);
        else
            npix = npix_raw;

        done_sum = pixels_done_reg + npix;
        fin      = (done_sum >= total_reg) || (n_reg == RES_W'(MAX_RESULTS - 1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (oob || empty)
                begin
                    if (out_free)
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = fin ? ST_IDLE : ST_DIV;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        latch_cmd   = 1'b0;
        load_total  = 1'b0;
        load_status = 1'b0;
        load_chunk  = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
                latch_cmd = cmd_fire;
            ST_CHECK:
            begin
                if (oob || empty)
                    load_status = out_free;
                else
                    load_total = 1'b1;
            end
            ST_DIV:
                div_start = 1'b1;
            ST_DIV_WAIT:
                div_start = 1'b0;
            ST_EMIT:
                load_chunk = out_free;
            default:
                div_start = 1'b0;
        endcase
    end

    assign div_req.start    = div_start;
    assign div_req.dividend = pixels_done_reg;
    assign div_req.divisor  = xw_reg;

    frcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        pixels_done_next = pixels_done_reg;
        n_next           = n_reg;
        out_valid_next   = out_valid_reg && !chunk.ready;
        out_next         = out_reg;

        if (load_total)
        begin
            pixels_done_next = '0;
            n_next           = '0;
        end

        if (load_status)
        begin
            out_next        = '0;
            out_next.status = oob ? STATUS_REJECT : STATUS_EMPTY;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
        end
        else if (load_chunk)
        begin
            out_next.win_x_first  = x1_sum[COORD_W-1:0];
            out_next.win_x_last   = x2_clip;
            out_next.win_y_first  = y1_sum[COORD_W-1:0];
            out_next.win_y_last   = y2_clip;
            out_next.pixel_count  = COUNT_W'(npix);
            out_next.color_rgb565 = to_565(color_reg);
            out_next.status       = STATUS_CHUNK;
            out_next.last         = fin;
            out_valid_next        = 1'b1;
            pixels_done_next      = fin ? '0 : done_sum;
            n_next                = n_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pixels_done_reg <= '0;
            n_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pixels_done_reg <= pixels_done_next;
            n_reg           <= n_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (latch_cmd)
        begin
            color_reg <= cmd.color_rgb888;
            xs_reg    <= cmd.x_start;
            xw_reg    <= cmd.x_width;
            ys_reg    <= cmd.y_start;
            yh_reg    <= cmd.y_span;
        end
        if (load_total)
            total_reg <= TOTAL_W'(product);
        out_reg <= out_next;
    end

    assign chunk.valid        = out_valid_reg;
    assign chunk.win_x_first  = out_reg.win_x_first;
    assign chunk.win_x_last   = out_reg.win_x_last;
    assign chunk.win_y_first  = out_reg.win_y_first;
    assign chunk.win_y_last   = out_reg.win_y_last;
    assign chunk.pixel_count  = out_reg.pixel_count;
    assign chunk.color_rgb565 = out_reg.color_rgb565;
    assign chunk.status       = out_reg.status;
    assign chunk.last         = out_reg.last;

endmodule

`default_nettype wire

// File: rtl/frcs_checker.sv
// ----------------------------------------------------------------------------
// frcs_checker
// port-level checks of the fill rectangle chunk splitter, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "fill_rect_chunk_splitter_assert.svh"

module frcs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          chunk_valid,
    input logic                          chunk_ready,
    input logic [frcs_pkg::COORD_W-1:0]  chunk_win_x_first,
    input logic [frcs_pkg::COORD_W-1:0]  chunk_win_x_last,
    input logic [frcs_pkg::COORD_W-1:0]  chunk_win_y_first,
    input logic [frcs_pkg::COORD_W-1:0]  chunk_win_y_last,
    input logic [frcs_pkg::COUNT_W-1:0]  chunk_pixel_count,
    input logic [frcs_pkg::RGB565_W-1:0] chunk_color_rgb565,
    input logic [frcs_pkg::STATUS_W-1:0] chunk_status,
    input logic                          chunk_last
);
    import frcs_pkg::*;

    // a command in work blocks the next one
    `FRCS_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // rejected and empty items are final and carry no window
    `FRCS_ASSERT_NOW(a_flag_item_zero, clk, rst_n, chunk_valid && (chunk_status != STATUS_CHUNK), chunk_last && (chunk_pixel_count == '0) && (chunk_color_rgb565 == '0) && (chunk_win_x_first == '0) && (chunk_win_x_last == '0) && (chunk_win_y_first == '0) && (chunk_win_y_last == '0))

    // a chunk always has pixels and an ordered window
    `FRCS_ASSERT_NOW(a_chunk_window, clk, rst_n, chunk_valid && (chunk_status == STATUS_CHUNK), (chunk_pixel_count != '0) && (chunk_win_x_first <= chunk_win_x_last) && (chunk_win_y_first <= chunk_win_y_last))

    // a stalled item holds
    `FRCS_ASSERT_NEXT(a_stall_hold, clk, rst_n, chunk_valid && !chunk_ready, chunk_valid && $stable(chunk_pixel_count) && $stable(chunk_last) && $stable(chunk_win_x_first))

endmodule

bind fill_rect_chunk_splitter frcs_checker u_frcs_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .chunk_valid        (chunk.valid),
    .chunk_ready        (chunk.ready),
    .chunk_win_x_first  (chunk.win_x_first),
    .chunk_win_x_last   (chunk.win_x_last),
    .chunk_win_y_first  (chunk.win_y_first),
    .chunk_win_y_last   (chunk.win_y_last),
    .chunk_pixel_count  (chunk.pixel_count),
    .chunk_color_rgb565 (chunk.color_rgb565),
    .chunk_status       (chunk.status),
    .chunk_last         (chunk.last)
);

`default_nettype wire
